// File: rtl/pptd_pkg.sv
`timescale 1ns / 1ps
package pptd_pkg;

  // default configuration
  localparam int TASK_SLOTS_DEF     = 16;
  localparam int PRIORITY_FIRST_DEF = 0;
  localparam int PRIORITY_FINAL_DEF = 3;

  // at most this many dispatch beats per tick
  localparam int RESULT_LIMIT = 16;
  localparam int FIRE_CNT_W   = $clog2(RESULT_LIMIT + 1);

  // item kinds
  localparam logic [1:0] KIND_REGISTER   = 2'd0;
  localparam logic [1:0] KIND_SET_ENABLE = 2'd1;
  localparam logic [1:0] KIND_TICK       = 2'd2;

  // register word indexes
  localparam logic REG_SCHED_ON = 1'b0;

  // per-slot static settings, written once at registration
  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] interval;
  } task_cfg_t;

  // write request into the task store
  typedef struct packed {
    logic        cfg_we;
    logic        run_we;
    task_cfg_t   cfg;
    logic [31:0] last_run;
  } task_wr_t;

endpackage

// File: rtl/periodic_priority_task_dispatcher.sv
// register, set-enable, unknown and idle-tick items pass through the response state to the output register
// tick: scans every registered slot at each level from first to final, one slot read per cycle
//   from the task store unless a fired slot waits on a stalled output; stops at RESULT_LIMIT fires
// throughput: one item at a time, next item accepted once the last beat is registered
// reset: rst_ni async active low, clears task count, enable bits and handshake state;
//   scheduler_on resets to 1, task memories are not cleared (slots are written before use)
`timescale 1ns / 1ps
module periodic_priority_task_dispatcher #(
  parameter int TASK_SLOTS     = pptd_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_FIRST = pptd_pkg::PRIORITY_FIRST_DEF,
  parameter int PRIORITY_FINAL = pptd_pkg::PRIORITY_FINAL_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] now_time_i,
  input  logic [31:0] interval_i,
  input  logic [7:0]  priority_req_i,
  input  logic [7:0]  task_index_i,
  input  logic        enable_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        fired_o,
  output logic [3:0]  task_slot_o,
  output logic [4:0]  task_total_o,
  output logic        last_o
);
  import pptd_pkg::*;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // scheduler enable register, word 0
  logic sched_on_q, sched_on_d;
  logic cfg_wr;
  logic reg_hit;

  // store traffic between the sequencer and the memories
  logic [SLOT_W-1:0] wr_addr;
  task_wr_t          wr;
  logic [SLOT_W-1:0] rd_addr;
  task_cfg_t         rd_cfg;
  logic [31:0]       rd_last_run;

  // word index is paddr[2]; the port never waits
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_SCHED_ON);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    sched_on_d = sched_on_q;
    if (cfg_wr && reg_hit) begin
      sched_on_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_on_q <= 1'b1;
    end else begin
      sched_on_q <= sched_on_d;
    end
  end

  // read back, unmapped word reads as zero
  assign prdata = reg_hit ? {31'd0, sched_on_q} : 32'd0;

  // per-slot interval, priority and last-run time, one read port
  pptd_task_store #(
    .TASK_SLOTS (TASK_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_store (
    .clk_i         (clk_i),
    .wr_addr_i     (wr_addr),
    .wr_i          (wr),
    .rd_addr_i     (rd_addr),
    .rd_cfg_o      (rd_cfg),
    .rd_last_run_o (rd_last_run)
  );

  // item sequencer: table updates, tick scan over levels and slots, output beats
  pptd_dispatch #(
    .TASK_SLOTS     (TASK_SLOTS),
    .PRIORITY_FIRST (PRIORITY_FIRST),
    .PRIORITY_FINAL (PRIORITY_FINAL),
    .SLOT_W         (SLOT_W)
  ) u_dispatch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sched_on_i     (sched_on_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .now_time_i     (now_time_i),
    .interval_i     (interval_i),
    .priority_req_i (priority_req_i),
    .task_index_i   (task_index_i),
    .enable_value_i (enable_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .fired_o        (fired_o),
    .task_slot_o    (task_slot_o),
    .task_total_o   (task_total_o),
    .last_o         (last_o),
    .wr_addr_o      (wr_addr),
    .wr_o           (wr),
    .rd_addr_o      (rd_addr),
    .rd_cfg_i       (rd_cfg),
    .rd_last_run_i  (rd_last_run)
  );

endmodule

// File: rtl/pptd_task_store.sv
`timescale 1ns / 1ps
module pptd_task_store #(
  parameter int TASK_SLOTS = pptd_pkg::TASK_SLOTS_DEF,
  parameter int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic                 clk_i,
  input  logic [SLOT_W-1:0]    wr_addr_i,
  input  pptd_pkg::task_wr_t   wr_i,
  input  logic [SLOT_W-1:0]    rd_addr_i,
  output pptd_pkg::task_cfg_t  rd_cfg_o,
  output logic [31:0]          rd_last_run_o
);
  import pptd_pkg::*;

  // interval and priority share one word, last-run time has its own memory
  task_cfg_t   cfg_mem [TASK_SLOTS];
  logic [31:0] run_mem [TASK_SLOTS];

  task_cfg_t   rd_cfg_q;
  logic [31:0] rd_run_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.cfg_we) begin
      cfg_mem[wr_addr_i] <= wr_i.cfg;
    end
    rd_cfg_q <= cfg_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.run_we) begin
      run_mem[wr_addr_i] <= wr_i.last_run;
    end
    rd_run_q <= run_mem[rd_addr_i];
  end

  assign rd_cfg_o      = rd_cfg_q;
  assign rd_last_run_o = rd_run_q;

endmodule

// File: rtl/pptd_dispatch.sv
`timescale 1ns / 1ps
module pptd_dispatch #(
  parameter int TASK_SLOTS     = pptd_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_FIRST = pptd_pkg::PRIORITY_FIRST_DEF,
  parameter int PRIORITY_FINAL = pptd_pkg::PRIORITY_FINAL_DEF,
  parameter int SLOT_W         = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 sched_on_i,
  // item channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [31:0]          now_time_i,
  input  logic [31:0]          interval_i,
  input  logic [7:0]           priority_req_i,
  input  logic [7:0]           task_index_i,
  input  logic                 enable_value_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 accepted_o,
  output logic                 fired_o,
  output logic [3:0]           task_slot_o,
  output logic [4:0]           task_total_o,
  output logic                 last_o,
  // task store
  output logic [SLOT_W-1:0]    wr_addr_o,
  output pptd_pkg::task_wr_t   wr_o,
  output logic [SLOT_W-1:0]    rd_addr_o,
  input  pptd_pkg::task_cfg_t  rd_cfg_i,
  input  logic [31:0]          rd_last_run_i
);
  import pptd_pkg::*;

  localparam int         CNT_W   = $clog2(TASK_SLOTS + 1);
  localparam logic [7:0] LVL_FIRST = 8'(PRIORITY_FIRST);
  localparam logic [7:0] LVL_FINAL = 8'(PRIORITY_FINAL);
  localparam logic       LVL_OK    = (PRIORITY_FIRST <= PRIORITY_FINAL);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_SCAN
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        used_q, used_d;
  logic [TASK_SLOTS-1:0]   en_q, en_d;
  logic [31:0]             now_q, now_d;
  // issue stage: slot whose read is launched
  logic                    iss_v_q, iss_v_d;
  logic [7:0]              iss_lvl_q, iss_lvl_d;
  logic [SLOT_W-1:0]       iss_slot_q, iss_slot_d;
  // evaluate stage: slot whose read data is present
  logic                    ev_v_q, ev_v_d;
  logic [7:0]              ev_lvl_q, ev_lvl_d;
  logic [SLOT_W-1:0]       ev_slot_q, ev_slot_d;
  // most recent fired slot, held until we know whether it is the final one
  logic                    pend_v_q, pend_v_d;
  logic [SLOT_W-1:0]       pend_slot_q, pend_slot_d;
  logic [FIRE_CNT_W-1:0]   fire_cnt_q, fire_cnt_d;
  // response held between accept and push for single-beat items
  logic                    resp_acc_q, resp_acc_d;
  logic [3:0]              resp_slot_q, resp_slot_d;
  // output register
  logic                    out_v_q, out_v_d;
  logic                    out_acc_q, out_acc_d;
  logic                    out_fire_q, out_fire_d;
  logic [3:0]              out_slot_q, out_slot_d;
  logic [4:0]              out_total_q, out_total_d;
  logic                    out_last_q, out_last_d;

  logic                    out_free;
  logic                    accept;
  logic [31:0]             elapsed;
  logic                    fire;
  logic                    hold;
  logic                    iss_last_slot;

  assign out_free      = !out_v_q || !out_stall_i;
  assign accept        = in_valid_i && (state_q == ST_IDLE);
  assign elapsed       = now_q - rd_last_run_i;
  assign fire          = (state_q == ST_SCAN) && ev_v_q && en_q[ev_slot_q] &&
                         (rd_cfg_i.prio == ev_lvl_q) && (elapsed >= rd_cfg_i.interval) &&
                         (fire_cnt_q < FIRE_CNT_W'(RESULT_LIMIT));
  assign hold          = fire && pend_v_q && !out_free;
  assign iss_last_slot = (iss_slot_q == SLOT_W'(used_q - CNT_W'(1)));

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    en_d        = en_q;
    now_d       = now_q;
    iss_v_d     = iss_v_q;
    iss_lvl_d   = iss_lvl_q;
    iss_slot_d  = iss_slot_q;
    ev_v_d      = ev_v_q;
    ev_lvl_d    = ev_lvl_q;
    ev_slot_d   = ev_slot_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    fire_cnt_d  = fire_cnt_q;
    resp_acc_d  = resp_acc_q;
    resp_slot_d = resp_slot_q;
    out_v_d     = out_v_q && out_stall_i;
    out_acc_d   = out_acc_q;
    out_fire_d  = out_fire_q;
    out_slot_d  = out_slot_q;
    out_total_d = out_total_q;
    out_last_d  = out_last_q;
    wr_addr_o   = ev_slot_q;
    wr_o        = '0;
    rd_addr_o   = iss_slot_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          resp_acc_d  = 1'b0;
          resp_slot_d = '0;
          state_d     = ST_RESP;
          unique case (kind_i)
            KIND_REGISTER: begin
              if (used_q != CNT_W'(TASK_SLOTS)) begin
                wr_addr_o           = used_q[SLOT_W-1:0];
                wr_o.cfg_we         = 1'b1;
                wr_o.run_we         = 1'b1;
                wr_o.cfg.prio       = priority_req_i;
                wr_o.cfg.interval   = interval_i;
                wr_o.last_run       = now_time_i;
                en_d[used_q[SLOT_W-1:0]] = 1'b1;
                used_d              = used_q + CNT_W'(1);
                resp_acc_d          = 1'b1;
                resp_slot_d         = 4'(used_q);
              end
            end
            KIND_SET_ENABLE: begin
              if ({1'b0, task_index_i} < 9'(used_q)) begin
                en_d[task_index_i[SLOT_W-1:0]] = enable_value_i;
                resp_acc_d = 1'b1;
              end
            end
            KIND_TICK: begin
              if (sched_on_i) begin
                state_d    = ST_SCAN;
                now_d      = now_time_i;
                iss_v_d    = (used_q != '0) && LVL_OK;
                iss_lvl_d  = LVL_FIRST;
                iss_slot_d = '0;
                ev_v_d     = 1'b0;
                pend_v_d   = 1'b0;
                fire_cnt_d = '0;
              end
            end
            default: begin
              // unknown kind: plain refusal beat
            end
          endcase
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_v_d     = 1'b1;
          out_acc_d   = resp_acc_q;
          out_fire_d  = 1'b0;
          out_slot_d  = resp_slot_q;
          out_total_d = 5'(used_q);
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (hold) begin
          // re-read the evaluated slot so its data is still there next cycle
          rd_addr_o = ev_slot_q;
        end else if (!iss_v_q && !ev_v_q) begin
          // scan finished: release the held slot, if any, as the final beat
          if (out_free) begin
            out_v_d     = 1'b1;
            out_acc_d   = 1'b0;
            out_fire_d  = pend_v_q;
            out_slot_d  = pend_v_q ? 4'(pend_slot_q) : 4'd0;
            out_total_d = 5'(used_q);
            out_last_d  = 1'b1;
            pend_v_d    = 1'b0;
            state_d     = ST_IDLE;
          end
        end else begin
          if (fire) begin
            if (pend_v_q) begin
              out_v_d     = 1'b1;
              out_acc_d   = 1'b0;
              out_fire_d  = 1'b1;
              out_slot_d  = 4'(pend_slot_q);
              out_total_d = 5'(used_q);
              out_last_d  = 1'b0;
            end
            pend_v_d      = 1'b1;
            pend_slot_d   = ev_slot_q;
            fire_cnt_d    = fire_cnt_q + FIRE_CNT_W'(1);
            wr_addr_o     = ev_slot_q;
            wr_o.run_we   = 1'b1;
            wr_o.last_run = now_q;
          end
          ev_v_d    = iss_v_q;
          ev_lvl_d  = iss_lvl_q;
          ev_slot_d = iss_slot_q;
          if (iss_v_q) begin
            if (iss_last_slot) begin
              iss_slot_d = '0;
              if (iss_lvl_q == LVL_FINAL) begin
                iss_v_d = 1'b0;
              end else begin
                iss_lvl_d = iss_lvl_q + 8'd1;
              end
            end else begin
              iss_slot_d = iss_slot_q + SLOT_W'(1);
            end
          end
          if (fire_cnt_d == FIRE_CNT_W'(RESULT_LIMIT)) begin
            iss_v_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      en_q       <= '0;
      iss_v_q    <= 1'b0;
      ev_v_q     <= 1'b0;
      pend_v_q   <= 1'b0;
      fire_cnt_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      en_q       <= en_d;
      iss_v_q    <= iss_v_d;
      ev_v_q     <= ev_v_d;
      pend_v_q   <= pend_v_d;
      fire_cnt_q <= fire_cnt_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    iss_lvl_q   <= iss_lvl_d;
    iss_slot_q  <= iss_slot_d;
    ev_lvl_q    <= ev_lvl_d;
    ev_slot_q   <= ev_slot_d;
    pend_slot_q <= pend_slot_d;
    resp_acc_q  <= resp_acc_d;
    resp_slot_q <= resp_slot_d;
    out_acc_q   <= out_acc_d;
    out_fire_q  <= out_fire_d;
    out_slot_q  <= out_slot_d;
    out_total_q <= out_total_d;
    out_last_q  <= out_last_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_v_q;
  assign accepted_o   = out_acc_q;
  assign fired_o      = out_fire_q;
  assign task_slot_o  = out_slot_q;
  assign task_total_o = out_total_q;
  assign last_o       = out_last_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TASK_SLOTS))
    else $error("task count above table size");

  a_fire_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_cnt_q <= FIRE_CNT_W'(RESULT_LIMIT))
    else $error("too many dispatches in one tick");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!iss_v_q && !ev_v_q && !pend_v_q))
    else $error("scan state left over in idle");

  a_fire_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !hold) |=> (pend_v_q && (pend_slot_q == $past(ev_slot_q))))
    else $error("fired slot not captured");

  a_hold_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |-> !wr_o.run_we)
    else $error("last-run written during a stall");

endmodule
